@@ rtl/wav_header_parser_sample_extractor_macros.svh @@
// assertion macros used by the rtl of the wav header parser
`ifndef WAV_HEADER_PARSER_SAMPLE_EXTRACTOR_MACROS_SVH
`define WAV_HEADER_PARSER_SAMPLE_EXTRACTOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WAVH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define WAVH_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

@@ rtl/wav_hdr_pkg.sv @@
// ----------------------------------------------------------------------------
// wav_hdr_pkg
// types, codes and constants of the wav header parser and sample extractor
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } wav_in_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [2:0]         error_code;
        logic [15:0]        format_code;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [31:0]        byte_rate;
        logic [15:0]        block_align;
        logic [15:0]        bits_per_sample;
        logic [31:0]        data_size;
        logic signed [15:0] sample_value;
        logic               last_sample;
    } wav_out_t;

    typedef enum logic [3:0] {
        PH_RIFF   = 4'd0,
        PH_RSIZE  = 4'd1,
        PH_WAVE   = 4'd2,
        PH_FMT    = 4'd3,
        PH_FLEN   = 4'd4,
        PH_FIELDS = 4'd5,
        PH_EXTLEN = 4'd6,
        PH_EXT    = 4'd7,
        PH_SKIP   = 4'd8,
        PH_CID    = 4'd9,
        PH_CLEN   = 4'd10,
        PH_DATA   = 4'd11,
        PH_IDLE   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_RIFF        = 3'd1,
        ERR_WAVE        = 3'd2,
        ERR_FMT         = 3'd3,
        ERR_NO_DATA     = 3'd4,
        ERR_UNSUPPORTED = 3'd5,
        ERR_TRUNCATED   = 3'd6
    } err_t;

    typedef struct packed {
        phase_t phase;
        logic   frames_zero;
        logic   align_legal;
    } wav_status_t;

    localparam logic [31:0] TAG_RIFF       = 32'h52494646;
    localparam logic [31:0] TAG_WAVE       = 32'h57415645;
    localparam logic [23:0] TAG_FMT        = 24'h666D74;
    localparam logic [31:0] TAG_DATA       = 32'h64617461;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
    localparam logic [15:0] FMT_PCM        = 16'h0001;
    localparam logic [15:0] EXT_MIN_LEN    = 16'd22;
    localparam logic [15:0] BITS_16        = 16'd16;
    localparam logic [15:0] ALIGN_MONO     = 16'd2;
    localparam logic [15:0] ALIGN_STEREO   = 16'd4;
    localparam logic [4:0]  GUID_FIRST     = 5'd6;
    localparam logic [4:0]  EXT_BYTES      = 5'd22;
    localparam logic [4:0]  FIELD_BYTES    = 5'd16;
    localparam logic [31:0] CONSUMED_BASE  = 32'd16;
    localparam logic [31:0] CONSUMED_EXTLN = 32'd18;
    localparam logic [31:0] CONSUMED_EXT   = 32'd40;

    // sub-format guid of integer pcm
    function automatic logic [7:0] pcm_guid_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:  v = 8'h01;
            4'd1:  v = 8'h00;
            4'd2:  v = 8'h00;
            4'd3:  v = 8'h00;
            4'd4:  v = 8'h00;
            4'd5:  v = 8'h00;
            4'd6:  v = 8'h10;
            4'd7:  v = 8'h00;
            4'd8:  v = 8'h80;
            4'd9:  v = 8'h00;
            4'd10: v = 8'h00;
            4'd11: v = 8'haa;
            4'd12: v = 8'h00;
            4'd13: v = 8'h38;
            4'd14: v = 8'h9b;
            4'd15: v = 8'h71;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/wav_hdr_core.sv @@
// ----------------------------------------------------------------------------
// wav_hdr_core
// parser state registers and the one-byte step that produces at most one result
// ----------------------------------------------------------------------------
module wav_hdr_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  wav_hdr_pkg::wav_in_t    in_item,
    output logic                    emit,
    output wav_hdr_pkg::wav_out_t   result,
    output wav_hdr_pkg::wav_status_t status
);
    import wav_hdr_pkg::*;

    phase_t      phase_reg, phase_next, phase_step, cur_phase;
    logic [4:0]  pos_reg, pos_next, cur_pos, pos_inc;
    logic [31:0] tag_reg, tag_next, cur_tag, tag_new;
    logic [31:0] field_reg, field_next, cur_field, field_put;
    logic [31:0] skip_reg, skip_next, cur_skip, skip_begin, consumed;
    logic [31:0] flen_reg, flen_next, cur_flen;
    logic        guid_reg, guid_next, cur_guid;
    logic [15:0] fmt_reg, fmt_next, cur_fmt;
    logic [15:0] ch_reg, ch_next, cur_ch;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [31:0] brate_reg, brate_next, cur_brate;
    logic [15:0] ba_reg, ba_next, cur_ba;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic [31:0] dsize_reg, dsize_next, cur_dsize;
    logic [31:0] frames_reg, frames_next, cur_frames;
    logic [1:0]  fbi_reg, fbi_next, cur_fbi;
    logic [2:0]  fbi_inc;
    logic [7:0]  low_reg, low_next, cur_low;
    logic [7:0]  b;
    logic [3:0]  p;
    logic        unsupported;
    kind_t       kind;
    err_t        err;
    logic        sample_out;
    logic        last_out;

    assign b = in_item.data_byte;

    // a start-of-file byte sees the reset state
    always_comb
    begin
        if (in_item.start_of_file)
        begin
            cur_phase  = PH_RIFF;
            cur_pos    = '0;
            cur_tag    = '0;
            cur_field  = '0;
            cur_skip   = '0;
            cur_flen   = '0;
            cur_guid   = 1'b1;
            cur_fmt    = '0;
            cur_ch     = '0;
            cur_rate   = '0;
            cur_brate  = '0;
            cur_ba     = '0;
            cur_bits   = '0;
            cur_dsize  = '0;
            cur_frames = '0;
            cur_fbi    = '0;
            cur_low    = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_pos    = pos_reg;
            cur_tag    = tag_reg;
            cur_field  = field_reg;
            cur_skip   = skip_reg;
            cur_flen   = flen_reg;
            cur_guid   = guid_reg;
            cur_fmt    = fmt_reg;
            cur_ch     = ch_reg;
            cur_rate   = rate_reg;
            cur_brate  = brate_reg;
            cur_ba     = ba_reg;
            cur_bits   = bits_reg;
            cur_dsize  = dsize_reg;
            cur_frames = frames_reg;
            cur_fbi    = fbi_reg;
            cur_low    = low_reg;
        end
    end

    assign tag_new = {cur_tag[23:0], b};
    assign pos_inc = cur_pos + 5'd1;
    assign p       = cur_pos[3:0];
    assign fbi_inc = {1'b0, cur_fbi} + 3'd1;

    always_comb
    begin
        field_put = cur_field;
        field_put[{cur_pos[1:0], 3'b000} +: 8] = b;
    end

    // bytes of the fmt chunk already read when the remainder skip starts
    always_comb
    begin
        priority if (cur_phase == PH_FIELDS)
            consumed = CONSUMED_BASE;
        else if (cur_phase == PH_EXTLEN)
            consumed = CONSUMED_EXTLN;
        else
            consumed = CONSUMED_EXT;
    end

    assign skip_begin  = (cur_flen > consumed) ? (cur_flen - consumed) : '0;
    assign unsupported = (cur_bits != BITS_16) ||
                         ((cur_ba != ALIGN_MONO) && (cur_ba != ALIGN_STEREO));

    // next state
    always_comb
    begin
        phase_step  = cur_phase;
        pos_next    = cur_pos;
        tag_next    = cur_tag;
        field_next  = cur_field;
        skip_next   = cur_skip;
        flen_next   = cur_flen;
        guid_next   = cur_guid;
        fmt_next    = cur_fmt;
        ch_next     = cur_ch;
        rate_next   = cur_rate;
        brate_next  = cur_brate;
        ba_next     = cur_ba;
        bits_next   = cur_bits;
        dsize_next  = cur_dsize;
        frames_next = cur_frames;
        fbi_next    = cur_fbi;
        low_next    = cur_low;

        unique case (cur_phase)
            PH_RIFF, PH_WAVE, PH_FMT, PH_CID:
            begin
                tag_next = tag_new;
                pos_next = pos_inc;
                if (cur_pos == 5'd3)
                begin
                    pos_next = '0;
                    unique case (cur_phase)
                        PH_RIFF:
                            phase_step = (tag_new == TAG_RIFF) ? PH_RSIZE : PH_IDLE;
                        PH_WAVE:
                            phase_step = (tag_new == TAG_WAVE) ? PH_FMT : PH_IDLE;
                        PH_FMT:
                        begin
                            if (tag_new[31:8] == TAG_FMT)
                            begin
                                field_next = '0;
                                phase_step = PH_FLEN;
                            end
                            else
                                phase_step = PH_IDLE;
                        end
                        default:
                        begin
                            field_next = '0;
                            phase_step = PH_CLEN;
                        end
                    endcase
                end
            end
            PH_RSIZE:
            begin
                pos_next = pos_inc;
                if (cur_pos == 5'd3)
                begin
                    pos_next   = '0;
                    phase_step = PH_WAVE;
                end
            end
            PH_FLEN:
            begin
                field_next = field_put;
                pos_next   = pos_inc;
                if (cur_pos == 5'd3)
                begin
                    pos_next   = '0;
                    flen_next  = field_put;
                    field_next = '0;
                    phase_step = PH_FIELDS;
                end
            end
            PH_FIELDS:
            begin
                priority if (p < 4'd2)
                    fmt_next[{p[0], 3'b000} +: 8] = b;
                else if (p < 4'd4)
                    ch_next[{p[0], 3'b000} +: 8] = b;
                else if (p < 4'd8)
                    rate_next[{p[1:0], 3'b000} +: 8] = b;
                else if (p < 4'd12)
                    brate_next[{p[1:0], 3'b000} +: 8] = b;
                else if (p < 4'd14)
                    ba_next[{p[0], 3'b000} +: 8] = b;
                else
                    bits_next[{p[0], 3'b000} +: 8] = b;
                pos_next = pos_inc;
                if (pos_inc == FIELD_BYTES)
                begin
                    pos_next = '0;
                    if (fmt_next == FMT_EXTENSIBLE)
                    begin
                        field_next = '0;
                        phase_step = PH_EXTLEN;
                    end
                    else
                    begin
                        skip_next  = skip_begin;
                        phase_step = (skip_begin != '0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_EXTLEN:
            begin
                field_next = field_put;
                pos_next   = pos_inc;
                if (cur_pos == 5'd1)
                begin
                    pos_next   = '0;
                    field_next = '0;
                    if (field_put[15:0] >= EXT_MIN_LEN)
                    begin
                        guid_next  = 1'b1;
                        phase_step = PH_EXT;
                    end
                    else
                    begin
                        skip_next  = skip_begin;
                        phase_step = (skip_begin != '0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_EXT:
            begin
                if ((cur_pos >= GUID_FIRST) && (cur_pos < EXT_BYTES) &&
                    (b != pcm_guid_byte(4'(cur_pos - GUID_FIRST))))
                    guid_next = 1'b0;
                pos_next = pos_inc;
                if (pos_inc == EXT_BYTES)
                begin
                    if (guid_next)
                        fmt_next = FMT_PCM;
                    pos_next   = '0;
                    skip_next  = skip_begin;
                    phase_step = (skip_begin != '0) ? PH_SKIP : PH_CID;
                end
            end
            PH_SKIP:
            begin
                skip_next = cur_skip - 32'd1;
                if (cur_skip == 32'd1)
                    phase_step = PH_CID;
            end
            PH_CLEN:
            begin
                field_next = field_put;
                pos_next   = pos_inc;
                if (cur_pos == 5'd3)
                begin
                    pos_next   = '0;
                    field_next = '0;
                    if (cur_tag == TAG_DATA)
                    begin
                        dsize_next = field_put;
                        if (unsupported)
                            phase_step = PH_IDLE;
                        else
                        begin
                            // block align is 2 or 4 here, so the divide is a shift
                            frames_next = (cur_ba == ALIGN_STEREO) ? (field_put >> 2)
                                                                   : (field_put >> 1);
                            fbi_next    = '0;
                            phase_step  = (frames_next != '0) ? PH_DATA : PH_IDLE;
                        end
                    end
                    else
                    begin
                        skip_next  = field_put;
                        phase_step = (field_put != '0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_DATA:
            begin
                if (cur_fbi == 2'd0)
                    low_next = b;
                else if (cur_fbi == 2'd1)
                begin
                    frames_next = cur_frames - 32'd1;
                    if (cur_frames == 32'd1)
                        phase_step = PH_IDLE;
                end
                fbi_next = ({13'd0, fbi_inc} >= cur_ba) ? 2'd0 : fbi_inc[1:0];
            end
            default:
                phase_step = PH_IDLE;
        endcase

        phase_next = in_item.end_of_file ? PH_IDLE : phase_step;
    end

    // result of this byte
    always_comb
    begin
        emit       = 1'b0;
        kind       = KIND_HEADER;
        err        = ERR_NONE;
        sample_out = 1'b0;
        last_out   = 1'b0;

        unique case (cur_phase)
            PH_RIFF:
                if ((cur_pos == 5'd3) && (tag_new != TAG_RIFF))
                begin
                    emit = 1'b1;
                    kind = KIND_ERROR;
                    err  = ERR_RIFF;
                end
            PH_WAVE:
                if ((cur_pos == 5'd3) && (tag_new != TAG_WAVE))
                begin
                    emit = 1'b1;
                    kind = KIND_ERROR;
                    err  = ERR_WAVE;
                end
            PH_FMT:
                if ((cur_pos == 5'd3) && (tag_new[31:8] != TAG_FMT))
                begin
                    emit = 1'b1;
                    kind = KIND_ERROR;
                    err  = ERR_FMT;
                end
            PH_CLEN:
                if ((cur_pos == 5'd3) && (cur_tag == TAG_DATA))
                begin
                    emit = 1'b1;
                    if (unsupported)
                    begin
                        kind = KIND_ERROR;
                        err  = ERR_UNSUPPORTED;
                    end
                end
            PH_DATA:
                if (cur_fbi == 2'd1)
                begin
                    emit       = 1'b1;
                    kind       = KIND_SAMPLE;
                    sample_out = 1'b1;
                    last_out   = (cur_frames == 32'd1);
                end
            default:
                emit = 1'b0;
        endcase

        // end of file in the sample data overrides this byte's result, or reports where the header stopped
        if (in_item.end_of_file)
        begin
            if (phase_step == PH_DATA)
            begin
                emit       = 1'b1;
                kind       = KIND_ERROR;
                err        = ERR_TRUNCATED;
                sample_out = 1'b0;
                last_out   = 1'b0;
            end
            else if ((phase_step != PH_IDLE) && !emit)
            begin
                emit = 1'b1;
                kind = KIND_ERROR;
                priority if (phase_step == PH_RIFF)
                    err = ERR_RIFF;
                else if ((phase_step == PH_RSIZE) || (phase_step == PH_WAVE))
                    err = ERR_WAVE;
                else if (phase_step == PH_FMT)
                    err = ERR_FMT;
                else
                    err = ERR_NO_DATA;
            end
        end
    end

    always_comb
    begin
        result.result_kind     = kind;
        result.error_code      = err;
        result.format_code     = fmt_next;
        result.channel_count   = ch_next;
        result.sample_rate     = rate_next;
        result.byte_rate       = brate_next;
        result.block_align     = ba_next;
        result.bits_per_sample = bits_next;
        result.data_size       = dsize_next;
        result.sample_value    = sample_out ? signed'({b, cur_low}) : 16'sd0;
        result.last_sample     = last_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            pos_reg    <= '0;
            tag_reg    <= '0;
            field_reg  <= '0;
            skip_reg   <= '0;
            flen_reg   <= '0;
            guid_reg   <= 1'b1;
            fmt_reg    <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            ba_reg     <= '0;
            bits_reg   <= '0;
            dsize_reg  <= '0;
            frames_reg <= '0;
            fbi_reg    <= '0;
            low_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tag_reg    <= tag_next;
            field_reg  <= field_next;
            skip_reg   <= skip_next;
            flen_reg   <= flen_next;
            guid_reg   <= guid_next;
            fmt_reg    <= fmt_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            ba_reg     <= ba_next;
            bits_reg   <= bits_next;
            dsize_reg  <= dsize_next;
            frames_reg <= frames_next;
            fbi_reg    <= fbi_next;
            low_reg    <= low_next;
        end
    end

    assign status.phase       = phase_reg;
    assign status.frames_zero = (frames_reg == '0);
    assign status.align_legal = (ba_reg == ALIGN_MONO) || (ba_reg == ALIGN_STEREO);

endmodule

@@ rtl/wav_hdr_obuf.sv @@
// ----------------------------------------------------------------------------
// wav_hdr_obuf
// two-entry result buffer: output register plus skid entry
// ----------------------------------------------------------------------------
module wav_hdr_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wav_hdr_pkg::wav_out_t push_data,
    output logic                  has_room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wav_hdr_pkg::wav_out_t out_data
);
    import wav_hdr_pkg::*;

    wav_out_t head_reg;
    wav_out_t skid_reg;
    logic     head_valid_reg;
    logic     skid_valid_reg;
    logic     pop;

    assign pop       = head_valid_reg && out_ready;
    // one push a cycle at most, so a free skid entry is always enough room
    assign has_room  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= push;
                else
                    head_valid_reg <= push;
            end
            else if (push)
            begin
                if (head_valid_reg)
                    skid_valid_reg <= 1'b1;
                else
                    head_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                    skid_reg <= push_data;
            end
            else if (push)
                head_reg <= push_data;
        end
        else if (push)
        begin
            if (head_valid_reg)
                skid_reg <= push_data;
            else
                head_reg <= push_data;
        end
    end

endmodule

@@ rtl/wav_header_parser_sample_extractor.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser_sample_extractor
// walks a wav file byte by byte, reports the fmt header and first-channel samples
// ----------------------------------------------------------------------------
//  channel  | signals                        | moves
//  ---------+--------------------------------+------------------------------
//  in       | in_valid / in_ready / in_data  | one file byte per request
//  out      | out_valid / out_ready / out_data | header, sample or error
//
//  one byte is taken per cycle while in_ready is high; the parser step is a
//  single pass from the state registers into the two-entry result buffer.
//  in_ready drops only when both result entries are held by a stalled sink
//  reset returns the parser to the riff tag check with an empty buffer
// ----------------------------------------------------------------------------
`include "wav_header_parser_sample_extractor_macros.svh"

module wav_header_parser_sample_extractor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wav_hdr_pkg::wav_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wav_hdr_pkg::wav_out_t out_data
);
    import wav_hdr_pkg::*;

    logic        accept;
    logic        emit;
    logic        push;
    wav_out_t    result;
    wav_status_t status;

    assign accept = in_valid && in_ready;
    assign push   = accept && emit;

    wav_hdr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_data),
        .emit    (emit),
        .result  (result),
        .status  (status)
    );

    wav_hdr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `WAVH_ASSERT(a_stall_needs_results, !in_ready |-> out_valid, "input stalled with no result held")
    `WAVH_ASSERT(a_data_has_frames, (status.phase == PH_DATA) |-> !status.frames_zero, "sample phase with no frames left")
    `WAVH_ASSERT(a_data_align, (status.phase == PH_DATA) |-> status.align_legal, "sample phase with unsupported block align")
    `WAVH_ASSERT_NEXT(a_last_goes_idle, push && (result.result_kind == KIND_SAMPLE) && result.last_sample, status.phase == PH_IDLE, "parser not idle after last sample")

endmodule
